/* rtl/fsfl_pkg.sv */
// ----------------------------------------------------------------------------
// fsfl_pkg
// Shared constants, codes and types of the fixed slot free list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fsfl_pkg;

    // Slab geometry.
    localparam int SLOTS  = 256;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int ADDR_W = 64;
    localparam int SIZE_W = 13;

    // Remainder of the slot division stays below size * SLOTS.
    localparam int REM_W  = SIZE_W + IDX_W;
    localparam int PROD_W = SIZE_W + IDX_W;
    localparam int CNT_W  = (IDX_W > 1) ? $clog2(IDX_W) : 1;

    // Smallest object size in use (pointer size).
    localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(8);

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = ADDR_W;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_SIZE  = 1'b1;

    localparam logic [ADDR_W-1:0] BASE_RESET = ADDR_W'(4096);
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

    // Request kinds.
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AL_RD,
        ST_AL_OUT,
        ST_FR_CHK,
        ST_FR_DIV,
        ST_FR_PUSH
    } fsfl_state_t;

endpackage

`default_nettype wire

/* rtl/fixed_slot_free_list_allocator_unit.sv */
// ----------------------------------------------------------------------------
// fixed_slot_free_list_allocator_unit
// Fixed-size slot allocator with a LIFO free list kept in a link memory.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries requests: s_tuser is the kind (0 allocate,
// 1 free) and s_tdata the address to free. Every allocate request makes one
// transfer on the master stream: m_tdata is the slot address, m_tuser is
// the grant flag (0 and a zero address when no slot is free). Free requests
// make no transfer. The configuration port writes the slab base address
// (index 0) and the object size (index 1, taken as at least 8 bytes); write
// it only while the block is idle.
// Timing: an allocate reads the link memory in ST_AL_RD, then loads the
// output register from the shared adder in ST_AL_OUT. A free passes the
// range check, one restoring division step per quotient bit on the one
// shared 64-bit adder, then the push. A free outside the slab ends after
// the check, and a null free ends in the idle state. The slave side is
// ready only in the idle state, so one request is in work at a time.
// Reset: all slots are free and chained so that the highest slot is handed
// out first. Per-entry valid bits stand in for the initial link values, so
// no clearing pass is needed and the block is ready right after reset.
// Stall: a result waits in the output register while m_tready is low; the
// next request is still taken, and a following allocate holds in its last
// step until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_slot_free_list_allocator_unit (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // Request stream.
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [fsfl_pkg::ADDR_W-1:0]           s_tdata,   // [63:0] address
    input  wire logic                                  s_tuser,   // [0] kind
    // Result stream.
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [fsfl_pkg::ADDR_W-1:0]                m_tdata,   // [63:0] address_res
    output logic                                       m_tuser,   // [0] granted
    // Configuration write port.
    input  wire logic                                  cfg_we,
    input  wire logic [fsfl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [fsfl_pkg::CFG_DATA_W-1:0]       cfg_data
);

    import fsfl_pkg::*;

    // Control state.
    fsfl_state_t         state_reg, state_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic                empty_reg, empty_next;
    logic [SLOTS-1:0]    vld_reg, vld_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    // Configuration.
    logic [ADDR_W-1:0]   base_reg;
    logic [SIZE_W-1:0]   size_reg;

    // Datapath.
    logic [ADDR_W-1:0]   offset_reg, offset_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [IDX_W-1:0]    quo_reg, quo_next;
    logic [PROD_W-1:0]   prod_reg;
    logic [IDX_W:0]      rd_word_reg;
    logic                rd_vld_reg;
    logic [ADDR_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                m_tuser_reg, m_tuser_next;

    // Link memory: {is_last, link} for each slot.
    logic [IDX_W:0]      link_mem [SLOTS];
    logic                mem_we;

    logic [SIZE_W-1:0]   size_use;
    logic                accept;
    logic                out_free;
    logic [IDX_W-1:0]    link_val;
    logic                last_val;

    // Shared adder and subtractor.
    logic [ADDR_W-1:0]   add_a, add_b;
    logic                add_sub;
    logic [ADDR_W:0]     add_sum;

    assign size_use = (size_reg < MIN_SIZE) ? MIN_SIZE : size_reg;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A slot never written still holds its reset link: slot i points to
    // slot i-1 and slot zero is the tail.
    always_comb begin
        if (rd_vld_reg) begin
            link_val = rd_word_reg[IDX_W-1:0];
            last_val = rd_word_reg[IDX_W];
        end else begin
            link_val = head_reg - IDX_W'(1);
            last_val = (head_reg == '0);
        end
    end

    // Operand selection for the shared unit. The carry out of a subtraction
    // is set when no borrow occurred, i.e. a >= b.
    always_comb begin
        add_a   = base_reg;
        add_b   = ADDR_W'(prod_reg);
        add_sub = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                add_a   = s_tdata;
                add_b   = base_reg;
                add_sub = 1'b1;
            end
            ST_FR_CHK: begin
                add_a   = offset_reg;
                add_b   = ADDR_W'(size_use) << IDX_W;
                add_sub = 1'b1;
            end
            ST_FR_DIV: begin
                add_a   = ADDR_W'(rem_reg);
                add_b   = ADDR_W'(size_use) << cnt_reg;
                add_sub = 1'b1;
            end
            default: begin
                add_a   = base_reg;
                add_b   = ADDR_W'(prod_reg);
                add_sub = 1'b0;
            end
        endcase
        add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                + (ADDR_W + 1)'(add_sub);
    end

    // Sequencer.
    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        empty_next    = empty_reg;
        vld_next      = vld_reg;
        cnt_next      = cnt_reg;
        offset_next   = offset_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        mem_we        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == KIND_ALLOC) begin
                        state_next = ST_AL_RD;
                    end else if (s_tdata != '0) begin
                        offset_next = add_sum[ADDR_W-1:0];
                        state_next  = ST_FR_CHK;
                    end
                end
            end
            ST_AL_RD: begin
                state_next = ST_AL_OUT;
            end
            ST_AL_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    if (empty_reg) begin
                        m_tdata_next = '0;
                        m_tuser_next = 1'b0;
                    end else begin
                        m_tdata_next = add_sum[ADDR_W-1:0];
                        m_tuser_next = 1'b1;
                        if (last_val) begin
                            empty_next = 1'b1;
                        end else begin
                            head_next = link_val;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_FR_CHK: begin
                // Offsets at or beyond the end of the slab are dropped.
                if (add_sum[ADDR_W]) begin
                    state_next = ST_IDLE;
                end else begin
                    rem_next   = offset_reg[REM_W-1:0];
                    quo_next   = '0;
                    cnt_next   = CNT_W'(IDX_W - 1);
                    state_next = ST_FR_DIV;
                end
            end
            ST_FR_DIV: begin
                // One restoring division step per cycle, top quotient bit first.
                if (add_sum[ADDR_W]) begin
                    rem_next = add_sum[REM_W-1:0];
                end
                quo_next[cnt_reg] = add_sum[ADDR_W];
                if (cnt_reg == '0) begin
                    state_next = ST_FR_PUSH;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_FR_PUSH: begin
                mem_we            = 1'b1;
                vld_next[quo_reg] = 1'b1;
                head_next         = quo_reg;
                empty_next        = 1'b0;
                state_next        = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= IDX_W'(SLOTS - 1);
            empty_reg    <= 1'b0;
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
            base_reg     <= BASE_RESET;
            size_reg     <= SIZE_RESET;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            empty_reg    <= empty_next;
            vld_reg      <= vld_next;
            m_tvalid_reg <= m_tvalid_next;
            cnt_reg      <= cnt_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_BASE_ADDRESS: base_reg <= cfg_data;
                    CFG_OBJECT_SIZE:  size_reg <= cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        offset_reg  <= offset_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        if (state_reg == ST_AL_RD) begin
            prod_reg   <= PROD_W'(head_reg) * PROD_W'(size_use);
            rd_vld_reg <= vld_reg[head_reg];
        end
    end

    // Link memory: written on a push, read at the head on an allocate.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            link_mem[quo_reg] <= {empty_reg, head_reg};
        end
        if (state_reg == ST_AL_RD) begin
            rd_word_reg <= link_mem[head_reg];
        end
    end

    // An allocate on an empty list must never report a grant.
    a_empty_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_AL_OUT && out_free && empty_reg) |=> !m_tuser_reg)
        else $error("grant reported on an empty free list");

    // A push always leaves the list non-empty with the freed slot on top.
    a_push_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FR_PUSH) |=> (!empty_reg && head_reg == $past(quo_reg)))
        else $error("push did not update the list head");

    // The division runs out its last step straight into the push.
    a_div_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FR_DIV && cnt_reg == '0) |=> (state_reg == ST_FR_PUSH))
        else $error("division sequence ended in the wrong state");

    // Free requests never produce a result transfer.
    a_free_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FR_DIV || state_reg == ST_FR_PUSH) |=> !$rose(m_tvalid_reg))
        else $error("result produced during a free");

endmodule

`default_nettype wire
